>>> design/outer_product_tile_accumulator_assert.svh
// Assertion macros for the outer product tile accumulator checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef OUTER_PRODUCT_TILE_ACCUMULATOR_ASSERT_SVH
`define OUTER_PRODUCT_TILE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define OPTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("opta check failed");

// Next-cycle implication.
`define OPTA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("opta check failed");

`endif

>>> design/opta_pkg.sv
// Shared types and constants of the outer product tile accumulator.
// No dependencies.
package opta_pkg;

  localparam int TILE_ROWS_DEF = 16;
  localparam int TILE_COLS_DEF = 64;
  localparam int EXP_W = 12;
  localparam int NORM_STAGES = 6;
  localparam int CELL_LATENCY = 17;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_ACC = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic signed [EXP_W-1:0] E_FLOOR = -12'sd188;
  localparam logic signed [EXP_W-1:0] E_SUBN = -12'sd149;
  localparam logic signed [EXP_W-1:0] R_MIN = 12'sd39;
  localparam logic signed [EXP_W-1:0] SHIFT_LIM = 12'sd64;
  localparam logic signed [EXP_W-1:0] BIAS_OUT = 12'sd150;
  localparam logic signed [EXP_W-1:0] EXP_MAX = 12'sd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_RD_ISSUE,
    ST_RD_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [31:0] operand;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [5:0]  column;
    logic [31:0] sum;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic        load;
    logic        acc;
    logic        fresh;
    logic [5:0]  index;
    logic [31:0] operand;
  } chain_t;

  typedef struct packed {
    logic                    act;
    logic [5:0]              index;
    logic [63:0]             np;
    logic signed [EXP_W-1:0] fp;
    logic [63:0]             nc;
    logic signed [EXP_W-1:0] fc;
    logic                    cz;
    logic                    sp;
    logic                    sc;
    logic                    spec;
    logic [31:0]             sval;
  } prod_stage_t;

  typedef struct packed {
    logic                    act;
    logic [5:0]              index;
    logic [63:0]             mx;
    logic [63:0]             my;
    logic signed [EXP_W-1:0] e;
    logic                    sx;
    logic                    sy;
    logic                    spec;
    logic [31:0]             sval;
  } align_stage_t;

  typedef struct packed {
    logic                    act;
    logic [5:0]              index;
    logic [63:0]             s;
    logic signed [EXP_W-1:0] e;
    logic                    sign;
    logic                    spec;
    logic [31:0]             sval;
  } sum_stage_t;

  typedef struct packed {
    logic                    act;
    logic [5:0]              index;
    logic [23:0]             q;
    logic                    rb;
    logic                    st;
    logic signed [EXP_W-1:0] elsb;
    logic                    sign;
    logic                    spec;
    logic [31:0]             sval;
  } round_stage_t;

endpackage

>>> design/opta_cell.sv
// One tile row: its A element, its row of accumulators and a pipelined fused multiply-add.
// Depends on opta_pkg.
module opta_cell #(
  parameter int ROW_ID = 0,
  parameter int TILE_COLS = opta_pkg::TILE_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  opta_pkg::chain_t                 chain_in,
  input  logic [$clog2(TILE_COLS)-1:0]     rd_col,
  output opta_pkg::chain_t                 chain_out,
  output logic [31:0]                      rdata
);

  localparam int COL_W = $clog2(TILE_COLS);
  localparam int NS = opta_pkg::NORM_STAGES;

  logic [31:0] acc_mem [TILE_COLS];
  opta_pkg::chain_t cmd;
  logic [31:0] a_val;
  logic [31:0] rd_data;
  logic [COL_W-1:0] rd_addr;

  assign rd_addr = chain_in.acc ? chain_in.index[COL_W-1:0] : rd_col;
  assign chain_out = cmd;
  assign rdata = rd_data;

  always_ff @(posedge clk) begin
    cmd <= chain_in;
    if (rst) begin
      cmd.load <= 1'b0;
      cmd.acc <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_in.load && chain_in.index == 6'(ROW_ID)) begin
      a_val <= chain_in.operand;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= acc_mem[rd_addr];
  end

  // unpack, specials and product
  logic [31:0] c_val, b_val;
  logic [7:0] ea, eb, ec, ea_adj, eb_adj, ec_adj;
  logic [22:0] fa, fb, fc;
  logic [23:0] ma, mb, mc;
  logic [47:0] mp;
  logic sa, sb, sc, sp;
  logic ainf, binf, cinf, anan, bnan, cnan, az, bz, cz;
  logic spec0;
  logic [31:0] sval0;
  opta_pkg::prod_stage_t pst [NS+1];

  always_comb begin
    c_val = cmd.fresh ? '0 : rd_data;
    b_val = cmd.operand;
    sa = a_val[31];
    sb = b_val[31];
    sc = c_val[31];
    sp = sa ^ sb;
    ea = a_val[30:23];
    eb = b_val[30:23];
    ec = c_val[30:23];
    fa = a_val[22:0];
    fb = b_val[22:0];
    fc = c_val[22:0];
    ainf = ea == 8'hFF;
    binf = eb == 8'hFF;
    cinf = ec == 8'hFF;
    anan = ainf && fa != '0;
    bnan = binf && fb != '0;
    cnan = cinf && fc != '0;
    az = ea == '0 && fa == '0;
    bz = eb == '0 && fb == '0;
    cz = ec == '0 && fc == '0;
    ea_adj = (ea == '0) ? 8'd1 : ea;
    eb_adj = (eb == '0) ? 8'd1 : eb;
    ec_adj = (ec == '0) ? 8'd1 : ec;
    ma = {ea != '0, fa};
    mb = {eb != '0, fb};
    mc = {ec != '0, fc};
    mp = ma * mb;
    spec0 = 1'b1;
    sval0 = '0;
    if (anan || bnan || cnan) begin
      sval0 = opta_pkg::QNAN;
    end else if ((ainf && bz) || (binf && az)) begin
      sval0 = opta_pkg::QNAN;
    end else if (ainf || binf) begin
      sval0 = (cinf && sc != sp) ? opta_pkg::QNAN : {sp, 8'hFF, 23'd0};
    end else if (cinf) begin
      sval0 = c_val;
    end else if (az || bz) begin
      sval0 = cz ? {sp & sc, 31'd0} : c_val;
    end else begin
      spec0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pst[0].act <= cmd.acc;
    pst[0].index <= cmd.index;
    pst[0].np <= {2'b00, mp, 14'd0};
    pst[0].fp <= {4'd0, ea_adj} + {4'd0, eb_adj} - 12'd314;
    pst[0].nc <= {2'b00, mc, 38'd0};
    pst[0].fc <= {4'd0, ec_adj} - 12'd188;
    pst[0].cz <= cz;
    pst[0].sp <= sp;
    pst[0].sc <= sc;
    pst[0].spec <= spec0;
    pst[0].sval <= sval0;
    if (rst) begin
      pst[0].act <= 1'b0;
    end
  end

  // normalize product and addend to bit 61
  for (genvar k = 0; k < NS; k++) begin : g_pnorm
    localparam int SH = 32 >> k;
    localparam logic signed [opta_pkg::EXP_W-1:0] SH_E = SH[opta_pkg::EXP_W-1:0];
    opta_pkg::prod_stage_t nx;
    always_comb begin
      nx = pst[k];
      if (pst[k].np[61 -: SH] == '0) begin
        nx.np = pst[k].np << SH;
        nx.fp = pst[k].fp - SH_E;
      end
      if (pst[k].nc[61 -: SH] == '0) begin
        nx.nc = pst[k].nc << SH;
        nx.fc = pst[k].fc - SH_E;
      end
    end
    always_ff @(posedge clk) begin
      pst[k+1] <= nx;
      if (rst) begin
        pst[k+1].act <= 1'b0;
      end
    end
  end

  // align the smaller term
  opta_pkg::prod_stage_t pn;
  opta_pkg::align_stage_t al, al_next;
  logic px, yzero;
  logic [63:0] mx, my, mask;
  logic signed [opta_pkg::EXP_W-1:0] ex, ey, span;

  always_comb begin
    pn = pst[NS];
    px = pn.cz || (pn.fp >= pn.fc);
    yzero = px && pn.cz;
    mx = px ? pn.np : pn.nc;
    my = px ? pn.nc : pn.np;
    ex = px ? pn.fp : pn.fc;
    ey = px ? pn.fc : pn.fp;
    span = ex - ey;
    mask = (64'd1 << span[5:0]) - 64'd1;
    al_next.act = pn.act;
    al_next.index = pn.index;
    al_next.mx = mx;
    al_next.e = ex;
    al_next.sx = px ? pn.sp : pn.sc;
    al_next.sy = px ? pn.sc : pn.sp;
    al_next.spec = pn.spec;
    al_next.sval = pn.sval;
    if (yzero) begin
      al_next.my = '0;
    end else if (span >= opta_pkg::SHIFT_LIM) begin
      al_next.my = 64'd1;
    end else begin
      al_next.my = (my >> span[5:0]) | {63'd0, (my & mask) != '0};
    end
  end

  always_ff @(posedge clk) begin
    al <= al_next;
    if (rst) begin
      al.act <= 1'b0;
    end
  end

  // add or subtract
  opta_pkg::sum_stage_t sst [NS+1];
  opta_pkg::sum_stage_t add_next;

  always_comb begin
    add_next.act = al.act;
    add_next.index = al.index;
    add_next.e = al.e;
    if (al.sx == al.sy) begin
      add_next.s = al.mx + al.my;
      add_next.sign = al.sx;
    end else if (al.mx >= al.my) begin
      add_next.s = al.mx - al.my;
      add_next.sign = al.sx;
    end else begin
      add_next.s = al.my - al.mx;
      add_next.sign = al.sy;
    end
    add_next.spec = al.spec || add_next.s == '0;
    add_next.sval = al.spec ? al.sval : '0;
  end

  always_ff @(posedge clk) begin
    sst[0] <= add_next;
    if (rst) begin
      sst[0].act <= 1'b0;
    end
  end

  // normalize the sum toward bit 62, stopping at the subnormal floor
  for (genvar k = 0; k < NS; k++) begin : g_snorm
    localparam int SH = 32 >> k;
    localparam logic signed [opta_pkg::EXP_W-1:0] SH_E = SH[opta_pkg::EXP_W-1:0];
    opta_pkg::sum_stage_t nx;
    always_comb begin
      nx = sst[k];
      if (sst[k].s[62 -: SH] == '0 && (sst[k].e - SH_E) >= opta_pkg::E_FLOOR) begin
        nx.s = sst[k].s << SH;
        nx.e = sst[k].e - SH_E;
      end
    end
    always_ff @(posedge clk) begin
      sst[k+1] <= nx;
      if (rst) begin
        sst[k+1].act <= 1'b0;
      end
    end
  end

  // drop low bits, keep round and sticky
  opta_pkg::sum_stage_t sn;
  opta_pkg::round_stage_t rs, rs_next;
  logic signed [opta_pkg::EXP_W-1:0] rr;
  logic [5:0] rsh;
  logic [63:0] sh, smask;

  always_comb begin
    sn = sst[NS];
    rr = opta_pkg::E_SUBN - sn.e;
    if (rr < opta_pkg::R_MIN) begin
      rr = opta_pkg::R_MIN;
    end
    rsh = rr[5:0] - 6'd1;
    sh = sn.s >> rsh;
    smask = (64'd1 << rsh) - 64'd1;
    rs_next.act = sn.act;
    rs_next.index = sn.index;
    rs_next.elsb = sn.e + rr;
    rs_next.sign = sn.sign;
    rs_next.spec = sn.spec;
    rs_next.sval = sn.sval;
    if (rr >= opta_pkg::SHIFT_LIM) begin
      rs_next.q = '0;
      rs_next.rb = 1'b0;
      rs_next.st = 1'b0;
    end else begin
      rs_next.q = sh[24:1];
      rs_next.rb = sh[0];
      rs_next.st = (sn.s & smask) != '0;
    end
  end

  always_ff @(posedge clk) begin
    rs <= rs_next;
    if (rst) begin
      rs.act <= 1'b0;
    end
  end

  // round, pack and write back
  logic [24:0] qi;
  logic [23:0] qn;
  logic signed [opta_pkg::EXP_W-1:0] el, be;
  logic [31:0] res;

  always_comb begin
    qi = {1'b0, rs.q} + {24'd0, rs.rb & (rs.st | rs.q[0])};
    el = rs.elsb;
    qn = qi[23:0];
    if (qi[24]) begin
      qn = qi[24:1];
      el = rs.elsb + 12'sd1;
    end
    be = el + opta_pkg::BIAS_OUT;
    if (rs.spec) begin
      res = rs.sval;
    end else if (!qn[23]) begin
      res = {rs.sign, 8'd0, qn[22:0]};
    end else if (be >= opta_pkg::EXP_MAX) begin
      res = {rs.sign, 8'hFF, 23'd0};
    end else begin
      res = {rs.sign, be[7:0], qn[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rs.act) begin
      acc_mem[rs.index[COL_W-1:0]] <= res;
    end
  end

endmodule

>>> design/opta_ctrl.sv
// Command decode, column valid bits, chain feed and row readout of the tile.
// Depends on opta_pkg.
module opta_ctrl #(
  parameter int TILE_ROWS = opta_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = opta_pkg::TILE_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  opta_pkg::cmd_word_t          cmd_word,
  output logic                         res_valid,
  input  logic                         res_stall,
  output opta_pkg::res_word_t          res_word,
  output opta_pkg::chain_t             chain,
  input  opta_pkg::chain_t             chain_tail,
  output logic [$clog2(TILE_COLS)-1:0] rd_col,
  input  logic [31:0]                  rdata [TILE_ROWS]
);

  localparam int COL_W = $clog2(TILE_COLS);
  localparam int ROW_W = $clog2(TILE_ROWS);
  localparam int CNT_W = $clog2(opta_pkg::CELL_LATENCY + 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_COLS - 1);

  opta_pkg::ctrl_state_t state, state_next;
  logic [TILE_COLS-1:0] col_valid;
  logic [CNT_W-1:0] wait_cnt;
  logic armed;
  logic [ROW_W-1:0] rd_row;
  logic [3:0] out_row;
  logic accept, col_ok, row_ok, res_free, last_col;
  logic [31:0] sum;

  assign cmd_stall = state != opta_pkg::ST_IDLE;
  assign col_ok = 32'(cmd_word.index) < TILE_COLS;
  assign row_ok = 32'(cmd_word.index) < TILE_ROWS;
  assign res_free = !res_valid || !res_stall;
  assign last_col = rd_col == COL_LAST;
  assign sum = col_valid[rd_col] ? rdata[rd_row] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= opta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept = 1'b0;
    case (state)
      opta_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          accept = 1'b1;
          if (cmd_word.kind == opta_pkg::KIND_ACC && col_ok) begin
            state_next = opta_pkg::ST_ACCUM;
          end else if (cmd_word.kind == opta_pkg::KIND_READ && row_ok) begin
            state_next = opta_pkg::ST_RD_ISSUE;
          end
        end
      end
      opta_pkg::ST_ACCUM: begin
        if (armed && wait_cnt == '0) begin
          state_next = opta_pkg::ST_IDLE;
        end
      end
      opta_pkg::ST_RD_ISSUE: begin
        if (res_free) begin
          state_next = opta_pkg::ST_RD_WAIT;
        end
      end
      opta_pkg::ST_RD_WAIT: begin
        state_next = last_col ? opta_pkg::ST_IDLE : opta_pkg::ST_RD_ISSUE;
      end
      default: begin
        state_next = opta_pkg::ST_IDLE;
      end
    endcase
  end

  // feed the row chain
  always_ff @(posedge clk) begin
    chain.load <= 1'b0;
    chain.acc <= 1'b0;
    chain.index <= cmd_word.index;
    chain.operand <= cmd_word.operand;
    chain.fresh <= !col_valid[cmd_word.index[COL_W-1:0]];
    if (accept && cmd_word.kind == opta_pkg::KIND_LOAD) begin
      chain.load <= 1'b1;
    end
    if (accept && cmd_word.kind == opta_pkg::KIND_ACC && col_ok) begin
      chain.acc <= 1'b1;
    end
    if (rst) begin
      chain.load <= 1'b0;
      chain.acc <= 1'b0;
    end
  end

  // column valid bits stand for the zeroed tile
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (accept && cmd_word.kind == opta_pkg::KIND_CLEAR) begin
      col_valid <= '0;
    end else if (accept && cmd_word.kind == opta_pkg::KIND_ACC && col_ok) begin
      col_valid[cmd_word.index[COL_W-1:0]] <= 1'b1;
    end
  end

  // wait for the last row's write back
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      wait_cnt <= '0;
    end else if (accept) begin
      armed <= 1'b0;
    end else if (chain_tail.acc) begin
      armed <= 1'b1;
      wait_cnt <= CNT_W'(opta_pkg::CELL_LATENCY);
    end else if (armed && wait_cnt != '0) begin
      wait_cnt <= wait_cnt - 1'b1;
    end
  end

  // readout
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= cmd_word.index[ROW_W-1:0];
      out_row <= cmd_word.index[3:0];
      rd_col <= '0;
    end else if (state == opta_pkg::ST_RD_WAIT && !last_col) begin
      rd_col <= rd_col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == opta_pkg::ST_RD_WAIT) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == opta_pkg::ST_RD_WAIT) begin
      res_word.row <= out_row;
      res_word.column <= 6'(rd_col);
      res_word.sum <= sum;
      res_word.last <= last_col;
    end
  end

endmodule

>>> design/outer_product_tile_accumulator.sv
// Single-precision outer-product tile: one cell per row, commands walk down the row chain.
// Load, clear and out-of-range words are taken without leaving idle. An accumulate word
// steps one row cell per cycle, and each cell's fused multiply-add pipeline is 17 stages
// deep to its write back; no new word is taken until the last row has written back.
// A read takes an issue and a wait state per column via each cell's registered memory port.
// Clearing is done by per-column valid bits, so reset and clear need no sweep.
// Depends on opta_pkg, opta_ctrl and opta_cell.
module outer_product_tile_accumulator #(
  parameter int TILE_ROWS = opta_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = opta_pkg::TILE_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  opta_pkg::cmd_word_t cmd_word,
  output logic                res_valid,
  input  logic                res_stall,
  output opta_pkg::res_word_t res_word
);

  localparam int COL_W = $clog2(TILE_COLS);

  opta_pkg::chain_t links [TILE_ROWS+1];
  logic [COL_W-1:0] rd_col;
  logic [31:0] row_data [TILE_ROWS];

  opta_ctrl #(
    .TILE_ROWS(TILE_ROWS),
    .TILE_COLS(TILE_COLS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word(cmd_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word(res_word),
    .chain(links[0]),
    .chain_tail(links[TILE_ROWS]),
    .rd_col(rd_col),
    .rdata(row_data)
  );

  for (genvar g = 0; g < TILE_ROWS; g++) begin : g_row
    opta_cell #(
      .ROW_ID(g),
      .TILE_COLS(TILE_COLS)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .chain_in(links[g]),
      .rd_col(rd_col),
      .chain_out(links[g+1]),
      .rdata(row_data[g])
    );
  end

endmodule

>>> design/opta_check.sv
// Port-level checks of the outer product tile accumulator, bound to the top level.
// Depends on opta_pkg and outer_product_tile_accumulator_assert.svh.
`include "outer_product_tile_accumulator_assert.svh"

module opta_check #(
  parameter int TILE_COLS = opta_pkg::TILE_COLS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                cmd_stall,
  input logic                res_valid,
  input logic                res_stall,
  input opta_pkg::res_word_t res_word
);

  `OPTA_ASSERT_IMP(a_last_col, res_valid && res_word.last, res_word.column == 6'(TILE_COLS - 1))
  `OPTA_ASSERT_IMP(a_idle_last, !cmd_stall && res_valid, res_word.last)
  `OPTA_ASSERT_NXT(a_mid_row_busy, res_valid && !res_stall && !res_word.last, cmd_stall)
  `OPTA_ASSERT_NXT(a_hold, res_valid && res_stall, res_valid && $stable(res_word))

endmodule

bind outer_product_tile_accumulator opta_check #(
  .TILE_COLS(TILE_COLS)
) u_check (
  .clk(clk),
  .rst(rst),
  .cmd_stall(cmd_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res_word(res_word)
);

>>> tb/tb_outer_product_tile_accumulator.sv
// Self-checking testbench for the binary32 outer-product tile accumulator.
// Predicts every read-out word with its own fused multiply-add; needs opta_pkg and the RTL.
`timescale 1ns / 1ps
module tb_outer_product_tile_accumulator;

  localparam int ROWS = 16;
  localparam int COLS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                clk;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  opta_pkg::cmd_word_t cmd_word;
  logic                res_valid;
  logic                res_stall;
  opta_pkg::res_word_t res_word;

  logic [31:0]         a_elems [ROWS];
  logic [31:0]         acc_tile [ROWS][COLS];
  opta_pkg::res_word_t pending_words [$];
  int                  mismatches;
  int                  idle_cycles;
  int                  res_hold;
  bit                  calm;

  outer_product_tile_accumulator uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic int top_bit(logic [63:0] v);
    int p;
    p = 63;
    while (p > 0 && v[p] == 1'b0) p--;
    return p;
  endfunction

  function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    bit sa, sb, sc, sp, sx, sy, sgn;
    bit ainf, binf, cinf, az, bz, cz;
    int ea, eb, ec, lp, lc, lx, ly, e, r, d, rs, elsb, be;
    logic [23:0] ma, mb;
    logic [63:0] mp, mc, mx, my, nx, ny, s, q, rem, half;
    sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
    ea = int'(a[30:23]); eb = int'(b[30:23]); ec = int'(c[30:23]);
    ainf = ea == 255; binf = eb == 255; cinf = ec == 255;
    az = ea == 0 && a[22:0] == 0; bz = eb == 0 && b[22:0] == 0; cz = ec == 0 && c[22:0] == 0;
    if ((ainf && a[22:0] != 0) || (binf && b[22:0] != 0) || (cinf && c[22:0] != 0))
      return opta_pkg::QNAN;
    if ((ainf && bz) || (binf && az)) return opta_pkg::QNAN;
    if (ainf || binf) begin
      if (cinf && sc != sp) return opta_pkg::QNAN;
      return {sp, 8'hFF, 23'h0};
    end
    if (cinf) return c;
    if (az || bz) begin
      if (cz) return {sp & sc, 31'h0};
      return c;
    end
    ma = {ea != 0, a[22:0]};
    mb = {eb != 0, b[22:0]};
    mp = {40'h0, ma} * {40'h0, mb};
    lp = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300;
    mc = cz ? 64'h0 : {40'h0, ec != 0, c[22:0]};
    lc = (ec != 0 ? ec : 1) - 150;
    if (mc == 0 || lp + top_bit(mp) >= lc + top_bit(mc)) begin
      mx = mp; lx = lp; sx = sp; my = mc; ly = lc; sy = sc;
    end else begin
      mx = mc; lx = lc; sx = sc; my = mp; ly = lp; sy = sp;
    end
    r = 61 - top_bit(mx);
    nx = mx << r;
    e = lx - r;
    ny = 64'h0;
    if (my != 0) begin
      d = ly - e;
      if (d >= 0) begin
        ny = my << d;
      end else if (-d >= 64) begin
        ny = 64'h1;
      end else begin
        rs = -d;
        ny = (my >> rs) | 64'((my & ((64'h1 << rs) - 1)) != 0);
      end
    end
    if (sx == sy) begin
      s = nx + ny; sgn = sx;
    end else if (nx >= ny) begin
      s = nx - ny; sgn = sx;
    end else begin
      s = ny - nx; sgn = sy;
    end
    if (s == 0) return 32'h0;
    r = top_bit(s) - 23;
    if (-149 - e > r) r = -149 - e;
    if (r <= 0) begin
      q = s << (-r);
    end else if (r >= 64) begin
      q = 64'h0;
    end else begin
      rem = s & ((64'h1 << r) - 1);
      half = 64'h1 << (r - 1);
      q = s >> r;
      if (rem > half || (rem == half && q[0])) q++;
    end
    elsb = e + r;
    if (q >= (64'h1 << 24)) begin
      q = q >> 1;
      elsb++;
    end
    if (q >= (64'h1 << 23)) begin
      be = elsb + 150;
      if (be >= 255) return {sgn, 8'hFF, 23'h0};
      return {sgn, be[7:0], q[22:0]};
    end
    return {sgn, q[30:0]};
  endfunction

  task automatic predict_tile(opta_pkg::cmd_word_t w);
    opta_pkg::res_word_t rw;
    case (w.kind)
      opta_pkg::KIND_LOAD: if (w.index < ROWS) a_elems[w.index] = w.operand;
      opta_pkg::KIND_ACC: begin
        if (w.index < COLS)
          for (int i = 0; i < ROWS; i++)
            acc_tile[i][w.index] = fused_mac(a_elems[i], w.operand, acc_tile[i][w.index]);
      end
      opta_pkg::KIND_CLEAR: begin
        for (int i = 0; i < ROWS; i++)
          for (int j = 0; j < COLS; j++) acc_tile[i][j] = 32'h0;
      end
      opta_pkg::KIND_READ: begin
        if (w.index < ROWS)
          for (int j = 0; j < COLS; j++) begin
            rw.row = w.index[3:0];
            rw.column = j[5:0];
            rw.sum = acc_tile[w.index][j];
            rw.last = (j == COLS - 1);
            pending_words.push_back(rw);
          end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] kind, logic [5:0] index, logic [31:0] operand);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= '{kind: kind, index: index, operand: operand};
    do @(posedge clk); while (cmd_stall);
    predict_tile('{kind: kind, index: index, operand: operand});
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: ;
      1: case ($urandom_range(0, 5))
           0: v = {v[31], 8'hFF, 23'h0};
           1: v = {v[31], 8'hFF, v[22:0] | 23'h1};
           2: v = {v[31], 31'h0};
           3: v = {v[31], 8'hFE, 23'h7FFFFF};
           4: v = {v[31], 8'h01, v[22:0]};
           default: v = {v[31], 8'h00, v[22:0]};
         endcase
      2: v = {v[31], 8'h00, v[22:0]};
      default: v = {v[31], 8'($urandom_range(112, 142)), v[22:0]};
    endcase
    return v;
  endfunction

  task automatic drain();
    wait (pending_words.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic test_a_load();
    logic [31:0] specials [9];
    specials = '{32'h7FC1_2345, 32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h8000_0000,
                 32'h0000_0001, 32'h7F7F_FFFF, 32'h0080_0000, 32'h807F_FFFF};
    for (int i = 0; i < ROWS; i++)
      send_word(opta_pkg::KIND_LOAD, i[5:0],
                (i >= 1 && i <= 9) ? specials[i - 1] : pick_operand());
    send_word(opta_pkg::KIND_LOAD, 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_empty_read();
    send_word(opta_pkg::KIND_READ, 6'd0, 32'h0);
    send_word(opta_pkg::KIND_READ, 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_special_values();
    send_word(opta_pkg::KIND_ACC, 6'd0, 32'h3F80_0000);
    send_word(opta_pkg::KIND_ACC, 6'd63, 32'h7F7F_FFFF);
    send_word(opta_pkg::KIND_ACC, 6'd63, 32'h7F7F_FFFF);
    send_word(opta_pkg::KIND_ACC, 6'd0, 32'hBF80_0000);
    send_word(opta_pkg::KIND_ACC, 6'd1, 32'h7F80_0000);
    send_word(opta_pkg::KIND_ACC, 6'd2, 32'h0000_0003);
    send_word(opta_pkg::KIND_ACC, 6'd40, 32'hFFC0_0001);
    send_word(opta_pkg::KIND_ACC, 6'd63, 32'h8000_0000);
    send_word(opta_pkg::KIND_READ, 6'd7, 32'h0);
    send_word(opta_pkg::KIND_READ, 6'd15, 32'h0);
  endtask

  task automatic test_clear();
    send_word(opta_pkg::KIND_CLEAR, 6'd21, 32'hA5A5_5A5A);
    send_word(opta_pkg::KIND_READ, 6'd4, 32'h0);
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    sent = 0;
    while (sent < 330) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0: begin
          send_word(opta_pkg::KIND_CLEAR, 6'($urandom), $urandom);
          sent++;
        end
        1, 2: begin
          send_word(opta_pkg::KIND_READ, 6'($urandom_range(0, ROWS - 1)), $urandom);
          sent++;
        end
        3: begin
          send_word(2'($urandom), 6'($urandom), $urandom);
          sent++;
        end
        default: begin
          n = $urandom_range(0, ROWS);
          for (int i = 0; i < n; i++) begin
            send_word(opta_pkg::KIND_LOAD, 6'($urandom_range(0, ROWS - 1)), pick_operand());
            sent++;
          end
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            send_word(opta_pkg::KIND_ACC, 6'($urandom_range(0, COLS - 1)), pick_operand());
            sent++;
          end
        end
      endcase
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    opta_pkg::res_word_t want;
    if (rst) begin
      res_stall <= 1'b0;
      res_hold = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", res_word);
        end else begin
          want = pending_words.pop_front();
          if (res_word.row !== want.row || res_word.column !== want.column ||
              res_word.sum !== want.sum || res_word.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, res_word);
          end
        end
        res_hold = calm ? 0 : $urandom_range(0, 17);
      end else if (res_hold > 0) begin
        res_hold--;
      end
      res_stall <= (res_hold > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_word = '0;
    res_stall = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    res_hold = 0;
    calm = 1'b0;
    for (int i = 0; i < ROWS; i++) begin
      a_elems[i] = 32'h0;
      for (int j = 0; j < COLS; j++) acc_tile[i][j] = 32'h0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_read();
    test_a_load();
    test_special_values();
    test_clear();
    test_random_traffic();
    cmd_valid <= 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
